// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, quiet while rst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked in the next cycle, same clock and reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/rsdr_pkg.sv -----
package rsdr_pkg;

    localparam int unsigned PIXEL_BYTES  = 6144;
    localparam int unsigned SCREEN_BYTES = 6912;
    localparam int unsigned LINE_PAIRS   = 96;

    // Pixel area is split in two banks by address bit 8 (source line parity).
    localparam int unsigned PIXEL_BANK_DEPTH = PIXEL_BYTES / 2;
    localparam int unsigned ATTR_DEPTH       = SCREEN_BYTES - PIXEL_BYTES;

    typedef enum logic [0:0] {
        MODE_WRITE  = 1'b0,
        MODE_RENDER = 1'b1
    } mode_t;

    typedef enum logic [0:0] {
        CFG_FLASH_INVERT = 1'b0,
        CFG_FLASH_ONLY   = 1'b1
    } cfg_reg_t;

    typedef logic [23:0] rgb_t;

    localparam rgb_t QUARTER_NORMAL [8] = '{
        24'h000000, 24'h000036, 24'h360000, 24'h360036,
        24'h003600, 24'h003636, 24'h363600, 24'h363636
    };

    localparam rgb_t QUARTER_BRIGHT [8] = '{
        24'h000000, 24'h00003F, 24'h3F0000, 24'h3F003F,
        24'h003F00, 24'h003F3F, 24'h3F3F00, 24'h3F3F3F
    };

    function automatic rgb_t quarter_color(input logic [2:0] idx, input logic bright);
        return bright ? QUARTER_BRIGHT[idx] : QUARTER_NORMAL[idx];
    endfunction

endpackage

// ----- hdl/rsdr_ram.sv -----
module rsdr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/retro_screen_downscale_render.sv -----
// Spectrum screen store and 2x2 downscaling renderer. A write transaction (mode 0) stores one
// byte of the 6912-byte screen image; a render transaction (mode 1) turns one column of a source
// line pair into four RGB pixels. busy is always low: one transaction is taken every cycle, with
// no gaps between writes and renders. A render that is drawn strobes done for one cycle once it
// has passed the screen RAM read, attribute decode and 2x2 color sum stages; results leave in
// start order and cannot be held off by the receiver. The per-cycle rate is set by the three
// screen RAMs, each read once per render: even-line pixel bank, odd-line pixel bank, attributes.
// Renders with line_pair above 95, and non-flashing cells while flash_only is set, give no
// result. The screen RAM needs no clearing: every byte must be written before a render reads it.
// cfg_ready is always high, so users must change configuration only while no render is in flight.
`include "assert_macros.svh"

module retro_screen_downscale_render
    import rsdr_pkg::*;
#(
    parameter int unsigned BORDER_LEFT = 16,
    parameter int unsigned BORDER_TOP  = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [12:0] write_address,
    input  logic [7:0]  write_byte,
    input  logic [4:0]  column,
    input  logic [6:0]  line_pair,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic        cfg_data,

    output logic        done,
    output logic [7:0]  pixel_x,
    output logic [6:0]  pixel_y,
    output logic [23:0] color_a,
    output logic [23:0] color_b,
    output logic [23:0] color_c,
    output logic [23:0] color_d
);

    localparam int unsigned PIX_AW  = $clog2(PIXEL_BANK_DEPTH);
    localparam int unsigned ATTR_AW = $clog2(ATTR_DEPTH);

    // ---------------- configuration ----------------
    logic flash_invert_reg;
    logic flash_only_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_invert_reg <= 1'b0;
            flash_only_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FLASH_INVERT: flash_invert_reg <= cfg_data;
                CFG_FLASH_ONLY:   flash_only_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ---------------- stage 0: RAM write / read issue ----------------
    logic              accept;
    logic              is_write;
    logic              render_ok;
    logic              wr_pix;
    logic              wr_attr;
    logic [PIX_AW-1:0] wr_pix_addr;
    logic [ATTR_AW-1:0] wr_attr_addr;
    logic [12:0]       attr_offset;
    logic [PIX_AW-1:0] rd_pix_addr;
    logic [ATTR_AW-1:0] rd_attr_addr;
    logic [7:0]        top_byte;
    logic [7:0]        bot_byte;
    logic [7:0]        attr_byte;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign is_write  = accept && (mode == MODE_WRITE);
    assign render_ok = accept && (mode == MODE_RENDER) && (32'(line_pair) < LINE_PAIRS);

    assign wr_pix       = is_write && (32'(write_address) < PIXEL_BYTES);
    assign wr_attr      = is_write && (32'(write_address) >= PIXEL_BYTES)
                          && (32'(write_address) < SCREEN_BYTES);
    // bank select is address bit 8; the rest packs into the bank index
    assign wr_pix_addr  = PIX_AW'({write_address[12:9], write_address[7:0]});
    assign attr_offset  = write_address - 13'(PIXEL_BYTES);
    assign wr_attr_addr = attr_offset[ATTR_AW-1:0];

    // line 2p: bits[2:0] = {p[1:0],0}, bits[5:3] = p[4:2], bits[7:6] = p[6:5]
    assign rd_pix_addr  = PIX_AW'({line_pair[6:5], line_pair[1:0], line_pair[4:2], column});
    assign rd_attr_addr = ATTR_AW'({line_pair[6:2], column});

    rsdr_ram #(.WIDTH(8), .DEPTH(PIXEL_BANK_DEPTH)) u_pix_even (
        .clk     (clk),
        .wr_en   (wr_pix && !write_address[8]),
        .wr_addr (wr_pix_addr),
        .wr_data (write_byte),
        .rd_en   (render_ok),
        .rd_addr (rd_pix_addr),
        .rd_data (top_byte)
    );

    rsdr_ram #(.WIDTH(8), .DEPTH(PIXEL_BANK_DEPTH)) u_pix_odd (
        .clk     (clk),
        .wr_en   (wr_pix && write_address[8]),
        .wr_addr (wr_pix_addr),
        .wr_data (write_byte),
        .rd_en   (render_ok),
        .rd_addr (rd_pix_addr),
        .rd_data (bot_byte)
    );

    rsdr_ram #(.WIDTH(8), .DEPTH(ATTR_DEPTH)) u_attr (
        .clk     (clk),
        .wr_en   (wr_attr),
        .wr_addr (wr_attr_addr),
        .wr_data (write_byte),
        .rd_en   (render_ok),
        .rd_addr (rd_attr_addr),
        .rd_data (attr_byte)
    );

    logic       s1_valid_reg;
    logic [4:0] s1_col_reg;
    logic [6:0] s1_pair_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= render_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (render_ok)
        begin
            s1_col_reg  <= column;
            s1_pair_reg <= line_pair;
        end
    end

    // ---------------- stage 1: attribute decode ----------------
    logic s2_valid_next;
    rgb_t ink_q;
    rgb_t paper_q;
    rgb_t s2_ink_next;
    rgb_t s2_paper_next;

    always_comb
    begin
        ink_q         = quarter_color(attr_byte[2:0], attr_byte[6]);
        paper_q       = quarter_color(attr_byte[5:3], attr_byte[6]);
        s2_valid_next = s1_valid_reg && !(flash_only_reg && !attr_byte[7]);
        if (attr_byte[7] && flash_invert_reg)
        begin
            s2_ink_next   = paper_q;
            s2_paper_next = ink_q;
        end
        else
        begin
            s2_ink_next   = ink_q;
            s2_paper_next = paper_q;
        end
    end

    logic       s2_valid_reg;
    rgb_t       s2_ink_reg;
    rgb_t       s2_paper_reg;
    logic [7:0] s2_top_reg;
    logic [7:0] s2_bot_reg;
    logic [7:0] s2_x_reg;
    logic [6:0] s2_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_next)
        begin
            s2_ink_reg   <= s2_ink_next;
            s2_paper_reg <= s2_paper_next;
            s2_top_reg   <= top_byte;
            s2_bot_reg   <= bot_byte;
            s2_x_reg     <= 8'(BORDER_LEFT) + {1'b0, s1_col_reg, 2'b00};
            s2_y_reg     <= 7'(BORDER_TOP) + s1_pair_reg;
        end
    end

    // ---------------- stage 2: 2x2 sum ----------------
    // Quarter levels top out at 0x3F, so four of them never carry across channels.
    rgb_t sum_next [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sum_next[k] = (s2_top_reg[7-2*k] ? s2_ink_reg : s2_paper_reg)
                        + (s2_top_reg[6-2*k] ? s2_ink_reg : s2_paper_reg)
                        + (s2_bot_reg[7-2*k] ? s2_ink_reg : s2_paper_reg)
                        + (s2_bot_reg[6-2*k] ? s2_ink_reg : s2_paper_reg);
        end
    end

    logic       done_reg;
    logic [7:0] x_reg;
    logic [6:0] y_reg;
    rgb_t       color_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            x_reg     <= s2_x_reg;
            y_reg     <= s2_y_reg;
            color_reg <= sum_next;
        end
    end

    assign done    = done_reg;
    assign pixel_x = x_reg;
    assign pixel_y = y_reg;
    assign color_a = color_reg[0];
    assign color_b = color_reg[1];
    assign color_c = color_reg[2];
    assign color_d = color_reg[3];

    // ---------------- checks ----------------
    `ASSERT_NEXT(a_write_no_render, accept && (mode == MODE_WRITE), !s1_valid_reg, "write transaction entered render pipe")
    `ASSERT_NEXT(a_pair_range, accept && (mode == MODE_RENDER) && (32'(line_pair) >= LINE_PAIRS), !s1_valid_reg, "out of range line pair entered render pipe")
    `ASSERT_NEXT(a_stage2_done, s2_valid_reg, done, "stage 2 item lost before output")
    `ASSERT_CLK(a_done_source, done |-> $past(s1_valid_reg, 2), "result without a render two cycles earlier")
    `ASSERT_NEXT(a_flash_gate, s1_valid_reg && flash_only_reg && !attr_byte[7], !s2_valid_reg, "non-flashing cell passed in flash-only mode")

endmodule
